// ----- sv/msep_pkg.sv -----
package msep_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int DELAY_W = 28;
  localparam int VALUE_W = 26;
  localparam int CNT_W   = 9;
  localparam int TEMPO_W = 24;
  localparam int DIVD_W  = 26;

  localparam logic [KIND_W-1:0] EV_START     = 3'd0;
  localparam logic [KIND_W-1:0] EV_TICKS     = 3'd1;
  localparam logic [KIND_W-1:0] EV_NOTE      = 3'd2;
  localparam logic [KIND_W-1:0] EV_TRACK_END = 3'd3;
  localparam logic [KIND_W-1:0] EV_TEMPO     = 3'd4;
  localparam logic [KIND_W-1:0] EV_VOLUME    = 3'd5;
  localparam logic [KIND_W-1:0] EV_NO_STATUS = 3'd6;
  localparam logic [KIND_W-1:0] EV_ZERO_TEMPO = 3'd7;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_FILE      = 2'd1;
  localparam logic [1:0] PH_TRACK_HDR = 2'd2;
  localparam logic [1:0] PH_TRACK     = 2'd3;

  localparam logic [31:0] FILE_TAG     = 32'h4D546864;
  localparam logic [DIVD_W-1:0] US_PER_MIN = 26'd60000000;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] SYSEX_END     = 8'hF7;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // take byte, run step logic
    logic div_start; // seed divider
    logic div_step;  // one restoring-division step
    logic emit;      // load output register
  } msep_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic has_result;
    logic need_div;
    logic div_last;
  } msep_stat_t;

endpackage

// ----- sv/msep_ctrl.sv -----
module msep_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  msep_pkg::msep_stat_t stat,
  output msep_pkg::msep_cmd_t  cmd
);
  import msep_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;
  logic       take;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          if (stat.need_div) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else if (stat.has_result) begin
            cmd.emit       = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("input taken while busy");
  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_last) |=> state == S_OUT) else $error("divider exit");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("emit lost");
endmodule

// ----- sv/msep_dp.sv -----
module msep_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [msep_pkg::BYTE_W-1:0] data_byte,
  input  msep_pkg::msep_cmd_t         cmd,
  output msep_pkg::msep_stat_t        stat,
  output logic [msep_pkg::KIND_W-1:0]  event_kind,
  output logic [msep_pkg::DELAY_W-1:0] delta_time,
  output logic [7:0]                  status_code,
  output logic [7:0]                  first_arg,
  output logic [7:0]                  second_arg,
  output logic [msep_pkg::VALUE_W-1:0] value_word
);
  import msep_pkg::*;

  // architectural parser state
  logic [31:0]        byte_history, byte_history_next;
  logic [1:0]         parse_phase, parse_phase_next;
  logic [DELAY_W-1:0] delay_accum, delay_accum_next;
  logic [7:0]         current_status, current_status_next;
  logic [7:0]         running_status, running_status_next;
  logic [CNT_W-1:0]   arg_counter, arg_counter_next;
  logic [7:0]         meta_kind, meta_kind_next;
  logic [7:0]         meta_len, meta_len_next;
  logic               expect_delay, expect_delay_next;
  logic               expect_status, expect_status_next;

  // step result
  logic               res;
  logic               div_req;
  logic [KIND_W-1:0]  r_kind;
  logic [DELAY_W-1:0] r_dt;
  logic [7:0]         r_st, r_a1, r_a2;
  logic [VALUE_W-1:0] r_val;
  logic [TEMPO_W-1:0] r_tempo;

  logic [31:0]        h;
  logic [7:0]         st_sel;
  logic               go;
  logic [DELAY_W-1:0] acc_or;

  always_comb begin
    h                   = {byte_history[23:0], data_byte};
    acc_or              = delay_accum | DELAY_W'(data_byte[6:0]);
    byte_history_next   = h;
    parse_phase_next    = parse_phase;
    delay_accum_next    = delay_accum;
    current_status_next = current_status;
    running_status_next = running_status;
    arg_counter_next    = arg_counter;
    meta_kind_next      = meta_kind;
    meta_len_next       = meta_len;
    expect_delay_next   = expect_delay;
    expect_status_next  = expect_status;
    res = 1'b0; div_req = 1'b0;
    r_kind = EV_START; r_dt = '0; r_st = '0; r_a1 = '0; r_a2 = '0; r_val = '0;
    r_tempo = h[TEMPO_W-1:0];
    st_sel = current_status;
    go = 1'b1;
    unique case (parse_phase)
      PH_FILE: begin
        arg_counter_next = arg_counter + 1'b1;
        if (arg_counter_next == CNT_W'(10)) begin
          parse_phase_next  = PH_TRACK_HDR;
          arg_counter_next  = '0;
          expect_delay_next = 1'b1;
          res = 1'b1; r_kind = EV_TICKS; r_val = VALUE_W'(h[15:0]);
        end
      end
      PH_TRACK_HDR: begin
        arg_counter_next = arg_counter + 1'b1;
        if (arg_counter_next == CNT_W'(8)) begin
          parse_phase_next  = PH_TRACK;
          arg_counter_next  = '0;
          expect_delay_next = 1'b1;
        end
      end
      PH_TRACK: begin
        if (expect_delay) begin
          if (data_byte[7]) begin
            delay_accum_next = {acc_or[DELAY_W-8:0], 7'b0};
          end else begin
            delay_accum_next    = acc_or;
            expect_delay_next   = 1'b0;
            byte_history_next   = '0;
            current_status_next = '0;
            expect_status_next  = 1'b1;
          end
          go = 1'b0;
        end else if (expect_status) begin
          arg_counter_next  = '0;
          byte_history_next = '0;
          if (data_byte[7]) begin
            st_sel = data_byte;
          end else if (running_status != 8'h00) begin
            st_sel = running_status;
            byte_history_next = {24'h0, data_byte};
            arg_counter_next  = CNT_W'(1);
          end else begin
            res = 1'b1; r_kind = EV_NO_STATUS;
            go = 1'b0;
          end
          if (go) begin
            if (st_sel[7:4] != 4'hF) st_sel = {st_sel[7:4], 4'h0};
            expect_status_next  = 1'b0;
            running_status_next = st_sel;
            current_status_next = st_sel;
          end
        end else begin
          arg_counter_next = arg_counter + 1'b1;
        end
        if (go) begin
          unique case (st_sel)
            8'h80, 8'h90, 8'hA0, 8'hB0, 8'hE0: begin
              if (arg_counter_next == CNT_W'(2)) begin
                res = 1'b1; r_kind = EV_NOTE; r_dt = delay_accum; r_st = st_sel;
                r_a1 = byte_history_next[15:8]; r_a2 = byte_history_next[7:0];
                expect_delay_next = 1'b1; delay_accum_next = '0;
                byte_history_next = '0;
              end
            end
            8'hC0, 8'hD0: begin
              if (arg_counter_next == CNT_W'(1)) begin
                expect_delay_next = 1'b1; delay_accum_next = '0;
                byte_history_next = '0;
              end
            end
            8'hFF: begin
              logic [7:0] mk, ml;
              mk = meta_kind; ml = meta_len;
              if (arg_counter_next == CNT_W'(1)) mk = data_byte;
              if (arg_counter_next == CNT_W'(2)) ml = data_byte;
              meta_kind_next = mk; meta_len_next = ml;
              r_tempo = byte_history_next[TEMPO_W-1:0];
              if (arg_counter_next >= CNT_W'(2) &&
                  (arg_counter_next - CNT_W'(2)) == {1'b0, ml}) begin
                expect_delay_next = 1'b1; delay_accum_next = '0;
                byte_history_next = '0;
                if (mk == META_EOT) begin
                  parse_phase_next = PH_IDLE; running_status_next = '0;
                  res = 1'b1; r_kind = EV_TRACK_END;
                end else if (mk == META_TEMPO) begin
                  res = 1'b1;
                  if (r_tempo == '0) r_kind = EV_ZERO_TEMPO;
                  else begin
                    r_kind = EV_TEMPO; div_req = 1'b1;
                  end
                end
              end
            end
            8'hF0, 8'hF7: begin
              if (data_byte == SYSEX_END) begin
                expect_delay_next = 1'b1; delay_accum_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (h == FILE_TAG) begin
          parse_phase_next = PH_FILE; arg_counter_next = '0;
          byte_history_next = '0; delay_accum_next = '0;
          expect_delay_next = 1'b1; running_status_next = '0;
          expect_status_next = 1'b0;
          res = 1'b1; r_kind = EV_START;
        end else if (h[23:16] == 8'h80 || h[23:16] == 8'h90) begin
          byte_history_next = '0;
          res = 1'b1; r_kind = EV_NOTE;
          r_st = h[23:16]; r_a1 = h[15:8]; r_a2 = h[7:0];
        end else if (h[23:8] == 16'hF004) begin
          byte_history_next = '0;
          res = 1'b1; r_kind = EV_VOLUME; r_a2 = h[7:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_history <= '0; parse_phase <= PH_IDLE; delay_accum <= '0;
      current_status <= '0; running_status <= '0; arg_counter <= '0;
      meta_kind <= '0; meta_len <= '0; expect_delay <= 1'b0;
      expect_status <= 1'b0;
    end else if (cmd.load) begin
      byte_history <= byte_history_next; parse_phase <= parse_phase_next;
      delay_accum <= delay_accum_next; current_status <= current_status_next;
      running_status <= running_status_next; arg_counter <= arg_counter_next;
      meta_kind <= meta_kind_next; meta_len <= meta_len_next;
      expect_delay <= expect_delay_next; expect_status <= expect_status_next;
    end
  end

  // Restoring divider: one quotient bit per cycle
  logic [DIVD_W-1:0]  quo;
  logic [TEMPO_W:0]   rem;
  logic [TEMPO_W-1:0] dvs;
  logic [4:0]         div_cnt;
  logic [TEMPO_W:0]   rem_sh;
  logic [TEMPO_W+1:0] rem_diff;

  assign rem_sh   = {rem[TEMPO_W-1:0], quo[DIVD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= US_PER_MIN; rem <= '0; dvs <= r_tempo;
      div_cnt <= 5'(DIVD_W - 1);
    end else if (cmd.div_step) begin
      if (!rem_diff[TEMPO_W+1]) begin
        rem <= rem_diff[TEMPO_W:0];
        quo <= {quo[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIVD_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // held result fields while dividing
  logic [KIND_W-1:0] h_kind;
  logic              from_div;
  always_ff @(posedge clk) begin
    if (rst) from_div <= 1'b0;
    else if (cmd.load) from_div <= div_req;
    if (cmd.load) h_kind <= r_kind;
  end

  assign stat.has_result = res;
  assign stat.need_div   = div_req;
  assign stat.div_last   = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.load) begin
        event_kind <= r_kind; delta_time <= r_dt; status_code <= r_st;
        first_arg <= r_a1; second_arg <= r_a2; value_word <= r_val;
      end else begin
        event_kind <= h_kind; delta_time <= '0; status_code <= '0;
        first_arg <= '0; second_arg <= '0; value_word <= quo;
      end
    end
  end

  a_div_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> r_kind == EV_TEMPO) else $error("divide for non-tempo");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> r_tempo != '0) else $error("divide by zero");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.load) |-> from_div) else $error("late emit without divide");
endmodule

// ----- sv/midi_stream_event_parser.sv -----
// MIDI byte-stream event parser. One byte per request on data_byte; each
// byte yields zero or one event request on the output channel. Outside a
// file it recognizes the "MThd" tag and raw live note on/off and volume
// commands; inside a file it walks the header, track header and track
// events (delta time, running status, channel events, end of track, tempo).
// Most bytes need no extra work: the event is in the output register right
// after the accepting edge, and the input is ready again as soon as the
// output register can accept. A tempo meta event runs a restoring divider
// (60,000,000 / tempo) one quotient bit per cycle, then loads the output
// register, later if the output is still held. Reset clears all parser
// state; no clearing pass.
module midi_stream_event_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [msep_pkg::BYTE_W-1:0]  data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [msep_pkg::KIND_W-1:0]  event_kind,
  output logic [msep_pkg::DELAY_W-1:0] delta_time,
  output logic [7:0]                   status_code,
  output logic [7:0]                   first_arg,
  output logic [7:0]                   second_arg,
  output logic [msep_pkg::VALUE_W-1:0] value_word
);
  import msep_pkg::*;

  msep_cmd_t  cmd;
  msep_stat_t stat;

  // sequencing: accept, divide, present
  msep_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  // parser state, divider and output register
  msep_dp u_dp (
    .clk(clk), .rst(rst), .data_byte(data_byte), .cmd(cmd), .stat(stat),
    .event_kind(event_kind), .delta_time(delta_time),
    .status_code(status_code), .first_arg(first_arg),
    .second_arg(second_arg), .value_word(value_word)
  );
endmodule

// ----- tb/sv/midi_event_checker.sv -----
`timescale 1ns / 100ps
module midi_event_checker
  import msep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [KIND_W-1:0]    event_kind,
  input  logic [DELAY_W-1:0]   delta_time,
  input  logic [7:0]           status_code,
  input  logic [7:0]           first_arg,
  input  logic [7:0]           second_arg,
  input  logic [VALUE_W-1:0]   value_word,
  output int                   fail_count,
  output int                   pending_events,
  output int                   event_total
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DELAY_W-1:0] dt;
    logic [7:0]         st;
    logic [7:0]         a1;
    logic [7:0]         a2;
    logic [VALUE_W-1:0] val;
  } midi_event_t;

  midi_event_t expected_events[$];

  logic [31:0]        hist;
  logic [1:0]         phase;
  logic [DELAY_W-1:0] delay_acc;
  logic [7:0]         cur_st;
  logic [7:0]         run_st;
  logic [CNT_W-1:0]   arg_cnt;
  logic [7:0]         meta_k;
  logic [7:0]         meta_l;
  logic               want_delay;
  logic               want_status;

  function automatic midi_event_t mk(logic [KIND_W-1:0] k, logic [DELAY_W-1:0] d,
                                     logic [7:0] s, logic [7:0] x, logic [7:0] y,
                                     logic [VALUE_W-1:0] v);
    midi_event_t e;
    e.kind = k; e.dt = d; e.st = s; e.a1 = x; e.a2 = y; e.val = v;
    return e;
  endfunction

  task automatic close_event();
    want_delay = 1'b1;
    delay_acc  = '0;
    hist       = '0;
  endtask

  task automatic parse_track_byte(input logic [7:0] b);
    logic [23:0] tempo;
    if (want_delay) begin
      delay_acc = delay_acc | DELAY_W'(b[6:0]);
      if (b[7]) begin
        delay_acc = delay_acc << 7;
      end else begin
        want_delay  = 1'b0;
        hist        = '0;
        cur_st      = '0;
        want_status = 1'b1;
      end
      return;
    end
    if (want_status) begin
      arg_cnt = '0;
      hist    = '0;
      if (b[7]) begin
        cur_st = b;
      end else if (run_st != 0) begin
        cur_st  = run_st;
        hist    = {24'd0, b};
        arg_cnt = 1;
      end else begin
        expected_events.push_back(mk(EV_NO_STATUS, 0, 0, 0, 0, 0));
        return;
      end
      if (cur_st[7:4] != 4'hF) cur_st = cur_st & 8'hF0;
      want_status = 1'b0;
      run_st      = cur_st;
    end else begin
      arg_cnt = arg_cnt + 1'b1;
    end
    case (cur_st)
      8'h80, 8'h90, 8'hA0, 8'hB0, 8'hE0: begin
        if (arg_cnt == 2) begin
          expected_events.push_back(mk(EV_NOTE, delay_acc, cur_st, hist[15:8], hist[7:0], 0));
          close_event();
        end
      end
      8'hC0, 8'hD0: begin
        if (arg_cnt == 1) close_event();
      end
      8'hFF: begin
        if (arg_cnt == 1) meta_k = b;
        if (arg_cnt == 2) meta_l = b;
        if (arg_cnt >= 2 && CNT_W'(arg_cnt - 2) == CNT_W'(meta_l)) begin
          tempo = hist[23:0];
          close_event();
          if (meta_k == META_EOT) begin
            phase  = PH_IDLE;
            run_st = '0;
            expected_events.push_back(mk(EV_TRACK_END, 0, 0, 0, 0, 0));
          end else if (meta_k == META_TEMPO) begin
            if (tempo == 0)
              expected_events.push_back(mk(EV_ZERO_TEMPO, 0, 0, 0, 0, 0));
            else
              expected_events.push_back(mk(EV_TEMPO, 0, 0, 0, 0,
                                           VALUE_W'(60000000 / tempo)));
          end
        end
      end
      8'hF0, 8'hF7: begin
        if (b == SYSEX_END) begin
          want_delay = 1'b1;
          delay_acc  = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    hist = {hist[23:0], b};
    case (phase)
      PH_FILE: begin
        arg_cnt = arg_cnt + 1'b1;
        if (arg_cnt == 10) begin
          phase = PH_TRACK_HDR; arg_cnt = '0; want_delay = 1'b1;
          expected_events.push_back(mk(EV_TICKS, 0, 0, 0, 0, VALUE_W'(hist[15:0])));
        end
      end
      PH_TRACK_HDR: begin
        arg_cnt = arg_cnt + 1'b1;
        if (arg_cnt == 8) begin
          phase = PH_TRACK; arg_cnt = '0; want_delay = 1'b1;
        end
      end
      PH_TRACK: parse_track_byte(b);
      default: begin
        if (hist == FILE_TAG) begin
          phase = PH_FILE; arg_cnt = '0; hist = '0; delay_acc = '0;
          want_delay = 1'b1; run_st = '0; want_status = 1'b0;
          expected_events.push_back(mk(EV_START, 0, 0, 0, 0, 0));
        end else if (hist[23:16] == 8'h80 || hist[23:16] == 8'h90) begin
          expected_events.push_back(mk(EV_NOTE, 0, hist[23:16], hist[15:8], hist[7:0], 0));
          hist = '0;
        end else if (hist[23:8] == 16'hF004) begin
          expected_events.push_back(mk(EV_VOLUME, 0, 0, 0, hist[7:0], 0));
          hist = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    midi_event_t got, want;
    if (rst) begin
      hist = '0; phase = PH_IDLE; delay_acc = '0; cur_st = '0; run_st = '0;
      arg_cnt = '0; meta_k = '0; meta_l = '0; want_delay = 0; want_status = 0;
      expected_events.delete();
      fail_count <= 0;
      event_total <= 0;
    end else begin
      // compare before predicting: a byte's event never leaves on its own edge
      if (out_valid && out_ready) begin
        got = mk(event_kind, delta_time, status_code, first_arg, second_arg, value_word);
        event_total <= event_total + 1;
        if (expected_events.size() == 0) begin
          if (fail_count < 10) $display("unexpected event %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte);
    end
    pending_events <= expected_events.size();
  end

endmodule

// ----- tb/sv/tb_midi_stream_event_parser.sv -----
`timescale 1ns / 100ps
module tb_midi_stream_event_parser;
  import msep_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [DELAY_W-1:0]   delta_time;
  logic [7:0]           status_code, first_arg, second_arg;
  logic [VALUE_W-1:0]   value_word;
  int                   fail_count, pending_events, event_total;

  // byte script, refilled by the generator tasks below
  logic [7:0] byte_script[$];
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  int         out_phase = 0;

  localparam int WATCHDOG_LIMIT = 4000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  midi_stream_event_parser dut (.*);

  midi_event_checker chk (.*);

  // Receiver: a repeating ready pattern with occasional random stalls,
  // plus long stretches of always-ready.
  always @(posedge clk) begin
    out_phase <= out_phase + 1;
    if (out_phase % 600 < 150) out_ready <= 1'b1;
    else out_ready <= ((out_phase % 7) != 3) && ($urandom_range(0, 4) != 0);
  end

  // Watchdog: cycles without any accepted request
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d events outstanding", pending_events);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push(input logic [7:0] b);
    byte_script.push_back(b);
  endtask

  // variable-length quantity, 1..4 bytes
  task automatic push_delay(input int unsigned v);
    logic [7:0] grp[4];
    int n;
    n = 0;
    do begin
      grp[n] = {1'b0, v[6:0]};
      v = v >> 7;
      n++;
    end while (v != 0 && n < 4);
    for (int i = n - 1; i >= 0; i--) push(i == 0 ? grp[i] : (grp[i] | 8'h80));
  endtask

  task automatic push_file_head(input logic [15:0] ticks);
    push(8'h4D); push(8'h54); push(8'h68); push(8'h64);
    for (int i = 0; i < 8; i++) push(i == 3 ? 8'd6 : 8'($urandom_range(0, 2)));
    push(ticks[15:8]); push(ticks[7:0]);
    // MTrk and length, content irrelevant
    for (int i = 0; i < 8; i++) push(8'($urandom));
  endtask

  task automatic push_tempo(input logic [23:0] t);
    push(8'hFF); push(META_TEMPO); push(8'd3);
    push(t[23:16]); push(t[15:8]); push(t[7:0]);
  endtask

  // a random track event after its delay; never an unknown system status
  task automatic push_track_event();
    int sel;
    int len;
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1, 2, 3: begin
        push(8'h80 + 8'($urandom_range(0, 6)) * 8'h10 + 8'($urandom_range(0, 15)));
        push(8'($urandom_range(0, 127))); push(8'($urandom_range(0, 127)));
        if (byte_script[$-2][7:4] inside {4'hC, 4'hD}) void'(byte_script.pop_back());
      end
      4, 5: begin  // running status
        push(8'($urandom_range(0, 127))); push(8'($urandom_range(0, 127)));
      end
      6: push_tempo($urandom_range(0, 5) == 0 ? 24'd0 : 24'($urandom));
      7: begin  // other meta, possibly holding F7
        len = $urandom_range(0, 5);
        push(8'hFF); push(8'($urandom_range(1, 127)) == META_EOT ? 8'h01 : 8'h03);
        push(8'(len));
        for (int i = 0; i < len; i++) push($urandom_range(0, 1) ? SYSEX_END : 8'($urandom));
      end
      8: begin  // sysex
        push($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) push(8'($urandom_range(0, 127)));
        push(SYSEX_END);
      end
      default: begin
        push(8'hB0 | 8'($urandom_range(0, 15)));
        push(8'($urandom)); push(8'($urandom));
      end
    endcase
  endtask

  task automatic push_track(input int events);
    push_file_head(16'($urandom));
    for (int i = 0; i < events; i++) begin
      push_delay($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200));
      push_track_event();
    end
    push_delay($urandom_range(0, 5));
    push(8'hFF); push(META_EOT); push(8'd0);
  endtask

  task automatic push_live();
    case ($urandom_range(0, 3))
      0: begin push(8'h90); push(8'($urandom)); push(8'($urandom)); end
      1: begin push(8'h80); push(8'($urandom)); push(8'($urandom)); end
      2: begin push(8'hF0); push(8'h04); push(8'($urandom)); end
      default: push(8'($urandom));
    endcase
  endtask

  // Sender: bursts of random length with random gaps; valid held until taken.
  task automatic send_all();
    int burst;
    int gap;
    while (byte_script.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && byte_script.size() != 0) begin
        in_valid  <= 1'b1;
        data_byte <= byte_script.pop_front();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        burst--;
      end
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: live extremes, then a small file with the special cases:
    // channel masking, missing status, zero tempo, max tempo, long delay.
    push(8'h90); push(8'hFF); push(8'h00);
    push(8'h80); push(8'h00); push(8'hFF);
    push(8'hF0); push(8'h04); push(8'hFF);
    push_file_head(16'hFFFF);
    push(8'h00); push(8'h05);                  // data byte with no status
    push(8'h00); push(8'h9F); push(8'h7F); push(8'h00);
    push(8'hFF); push(8'hFF); push(8'hFF); push(8'h7F);  // largest four-byte delay
    push(8'h12); push(8'h34);                  // running status
    push(8'h00); push_tempo(24'd0);
    push(8'h00); push_tempo(24'hFFFFFF);
    push(8'h00); push_tempo(24'd1);
    push(8'h00); push(8'hC5); push(8'h10);
    push(8'h00); push(8'hFF); push(META_EOT); push(8'd0);
    send_all();

    // Random: mostly well-formed files, live commands and noise between
    while (bytes_sent < 550) begin
      if ($urandom_range(0, 2) == 0) push_live();
      else push_track($urandom_range(1, 8));
      send_all();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d bytes (live commands, files with notes, tempo, meta, sysex);",
             bytes_sent);
    $display("checked %0d events, %0d still expected.", event_total, pending_events);
    if (fail_count == 0 && pending_events == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
